>>> hw/rtl/slhm_pkg.sv
`default_nettype none

package slhm_pkg;

    // Default history depth
    localparam int MAX_SMOOTH_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int PIX_W    = 8;
    localparam int LEN_CFG_W = 5;

    // Register indexes
    localparam int REG_COLOR_MODE = 0;
    localparam int REG_SMOOTH_LEN = 1;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic                 COLOR_MODE_RST = 1'b0;
    localparam logic [LEN_CFG_W-1:0] SMOOTH_LEN_RST = 5'd4;

    localparam logic MODE_AMP  = 1'b0;
    localparam logic MODE_FREQ = 1'b1;

    localparam logic [PIX_W-1:0] HUE_SPAN = 8'd192;
    localparam logic [PIX_W-1:0] BRI_FULL = 8'd255;
    localparam logic [PIX_W-1:0] BRI_MIN  = 8'd10;
    // amp on threshold: 10 * a < 1.0 in Q0.16
    localparam logic [3:0]       AMP_ON_MUL = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_MAP
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/smoothed_level_to_hue_mapper_core.sv
`default_nettype none

// Channel | Dir | Handshake              | Payload
// s_      | in  | s_tvalid / s_tready    | amp_sample, freq_sample
// m_      | out | m_tvalid / m_tready    | hue, brightness
// cfg     | in  | APB psel/penable/pready| color_mode @0x0, smooth_len @0x4
//
// Each item passes through the accept cycle, a full rotation of the history
// rings through the adders, one quotient bit per cycle from the restoring
// divider, and then the map/push step.
// s_tready is high only while idle. A finished result sits in the output
// register, so the next item is taken while it waits for m_tready.
// Reset clears both history rings to zero and the configuration registers to defaults.

module smoothed_level_to_hue_mapper_core #(
    parameter int MAX_SMOOTH = slhm_pkg::MAX_SMOOTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [31:0]                     s_tdata,  // amp_sample, freq_sample

    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [15:0]                     m_tdata,  // hue, brightness

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [slhm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [slhm_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [slhm_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready
);

    localparam int SW    = slhm_pkg::SAMPLE_W;
    localparam int SUM_W = SW + $clog2(MAX_SMOOTH + 1);
    localparam int DIV_W = $clog2(MAX_SMOOTH + 2);
    localparam int RCNT_W = $clog2(MAX_SMOOTH + 1);
    localparam int BCNT_W = $clog2(SUM_W + 1);

    // ---------------- configuration ----------------
    logic                             cfg_mode_reg;
    logic [slhm_pkg::LEN_CFG_W-1:0]   cfg_len_reg;
    logic                             cfg_wr;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode_reg <= slhm_pkg::COLOR_MODE_RST;
            cfg_len_reg  <= slhm_pkg::SMOOTH_LEN_RST;
        end else if (cfg_wr) begin
            if (reg_sel == 1'(slhm_pkg::REG_COLOR_MODE)) begin
                cfg_mode_reg <= pwdata[0];
            end else begin
                cfg_len_reg <= pwdata[slhm_pkg::LEN_CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == 1'(slhm_pkg::REG_SMOOTH_LEN)) begin
            prdata[slhm_pkg::LEN_CFG_W-1:0] = cfg_len_reg;
        end else begin
            prdata[0] = cfg_mode_reg;
        end
    end

    // clamp to history depth
    logic [31:0]      len_wide;
    logic [DIV_W-1:0] eff_len;
    logic [DIV_W-1:0] divisor;

    assign len_wide = (32'(cfg_len_reg) > 32'(MAX_SMOOTH)) ? 32'(MAX_SMOOTH)
                                                            : 32'(cfg_len_reg);
    assign eff_len  = len_wide[DIV_W-1:0];
    assign divisor  = eff_len + DIV_W'(1);

    // ---------------- sequencer ----------------
    slhm_pkg::state_t state_reg, state_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;

    logic s_acc;
    logic rcnt_last;
    logic bcnt_last;
    logic out_free;
    logic do_load, do_rot, do_div, do_push;

    assign s_acc     = s_tvalid && s_tready;
    assign rcnt_last = (rcnt_reg == RCNT_W'(MAX_SMOOTH - 1));
    assign bcnt_last = (bcnt_reg == BCNT_W'(SUM_W - 1));
    assign out_free  = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slhm_pkg::ST_IDLE: if (s_acc) state_next = slhm_pkg::ST_SUM;
            slhm_pkg::ST_SUM:  if (rcnt_last) state_next = slhm_pkg::ST_DIV;
            slhm_pkg::ST_DIV:  if (bcnt_last) state_next = slhm_pkg::ST_MAP;
            slhm_pkg::ST_MAP:  if (out_free) state_next = slhm_pkg::ST_IDLE;
            default:           state_next = slhm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        do_load   = 1'b0;
        do_rot    = 1'b0;
        do_div    = 1'b0;
        do_push   = 1'b0;
        rcnt_next = rcnt_reg;
        bcnt_next = bcnt_reg;
        case (state_reg)
            slhm_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                do_load   = s_acc;
                rcnt_next = '0;
                bcnt_next = '0;
            end
            slhm_pkg::ST_SUM: begin
                do_rot    = 1'b1;
                rcnt_next = rcnt_reg + RCNT_W'(1);
            end
            slhm_pkg::ST_DIV: begin
                do_div    = 1'b1;
                bcnt_next = bcnt_reg + BCNT_W'(1);
            end
            slhm_pkg::ST_MAP: begin
                do_push = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slhm_pkg::ST_IDLE;
            rcnt_reg  <= '0;
            bcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    // ---------------- history rings ----------------
    // A full rotation of MAX_SMOOTH steps presents each entry at tap 0
    // (newest first) and leaves the ring in its original order.
    logic [SW-1:0] amp_hist_reg  [MAX_SMOOTH];
    logic [SW-1:0] freq_hist_reg [MAX_SMOOTH];
    logic [SW-1:0] amp_avg;
    logic [SW-1:0] freq_avg;
    logic          push_freq;

    assign push_freq = do_push && (cfg_mode_reg == slhm_pkg::MODE_FREQ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SMOOTH; i++) begin
                amp_hist_reg[i]  <= '0;
                freq_hist_reg[i] <= '0;
            end
        end else if (do_rot) begin
            for (int i = 0; i < MAX_SMOOTH - 1; i++) begin
                amp_hist_reg[i]  <= amp_hist_reg[i+1];
                freq_hist_reg[i] <= freq_hist_reg[i+1];
            end
            amp_hist_reg[MAX_SMOOTH-1]  <= amp_hist_reg[0];
            freq_hist_reg[MAX_SMOOTH-1] <= freq_hist_reg[0];
        end else if (do_push) begin
            for (int i = 1; i < MAX_SMOOTH; i++) begin
                amp_hist_reg[i] <= amp_hist_reg[i-1];
            end
            amp_hist_reg[0] <= amp_avg;
            if (push_freq) begin
                for (int i = 1; i < MAX_SMOOTH; i++) begin
                    freq_hist_reg[i] <= freq_hist_reg[i-1];
                end
                freq_hist_reg[0] <= freq_avg;
            end
        end
    end

    // ---------------- sum and restoring divide ----------------
    // The dividend register doubles as the quotient shift register.
    logic [SUM_W-1:0] amp_acc_reg,  freq_acc_reg;
    logic [DIV_W:0]   amp_rem_reg,  freq_rem_reg;
    logic             take_entry;
    logic [DIV_W+1:0] amp_trial,    freq_trial;

    assign take_entry = (32'(rcnt_reg) < 32'(eff_len));
    assign amp_trial  = {amp_rem_reg, amp_acc_reg[SUM_W-1]} - (DIV_W+2)'(divisor);
    assign freq_trial = {freq_rem_reg, freq_acc_reg[SUM_W-1]} - (DIV_W+2)'(divisor);

    always_ff @(posedge aclk) begin
        if (do_load) begin
            amp_acc_reg  <= SUM_W'(s_tdata[15:0]);
            freq_acc_reg <= SUM_W'(s_tdata[31:16]);
            amp_rem_reg  <= '0;
            freq_rem_reg <= '0;
        end else if (do_rot) begin
            if (take_entry) begin
                amp_acc_reg  <= amp_acc_reg + SUM_W'(amp_hist_reg[0]);
                freq_acc_reg <= freq_acc_reg + SUM_W'(freq_hist_reg[0]);
            end
        end else if (do_div) begin
            if (!amp_trial[DIV_W+1]) begin
                amp_rem_reg <= amp_trial[DIV_W:0];
                amp_acc_reg <= {amp_acc_reg[SUM_W-2:0], 1'b1};
            end else begin
                amp_rem_reg <= {amp_rem_reg[DIV_W-1:0], amp_acc_reg[SUM_W-1]};
                amp_acc_reg <= {amp_acc_reg[SUM_W-2:0], 1'b0};
            end
            if (!freq_trial[DIV_W+1]) begin
                freq_rem_reg <= freq_trial[DIV_W:0];
                freq_acc_reg <= {freq_acc_reg[SUM_W-2:0], 1'b1};
            end else begin
                freq_rem_reg <= {freq_rem_reg[DIV_W-1:0], freq_acc_reg[SUM_W-1]};
                freq_acc_reg <= {freq_acc_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // average never exceeds full scale, so the low bits are the whole quotient
    assign amp_avg  = amp_acc_reg[SW-1:0];
    assign freq_avg = freq_acc_reg[SW-1:0];

    // ---------------- mapping ----------------
    logic [23:0] amp_x192, amp_x255, freq_x192;
    logic [23:0] hue_inv;
    logic [19:0] amp_x10;
    logic [7:0]  hue_val, bri_val;

    assign amp_x192  = 24'(amp_avg) * 24'(slhm_pkg::HUE_SPAN);
    assign amp_x255  = 24'(amp_avg) * 24'(slhm_pkg::BRI_FULL);
    assign freq_x192 = 24'(freq_avg) * 24'(slhm_pkg::HUE_SPAN);
    assign amp_x10   = 20'(amp_avg) * 20'(slhm_pkg::AMP_ON_MUL);
    assign hue_inv   = {slhm_pkg::HUE_SPAN, 16'h0000} - amp_x192;

    always_comb begin
        if (cfg_mode_reg == slhm_pkg::MODE_AMP) begin
            hue_val = hue_inv[23:16];
            bri_val = (amp_x10 < 20'h10000) ? '0 : slhm_pkg::BRI_FULL;
        end else begin
            hue_val = freq_x192[23:16];
            bri_val = (amp_x255[23:16] < slhm_pkg::BRI_MIN) ? '0 : amp_x255[23:16];
        end
    end

    // ---------------- output register ----------------
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            m_data_reg <= {bri_val, hue_val};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> bench/tb_smoothed_level_to_hue_mapper_core.sv
`timescale 1ns / 100ps

module tb_smoothed_level_to_hue_mapper_core;

    localparam int RAND_ITEMS = 600;
    localparam int SETTLE     = 48;
    localparam int LONG_HOLD  = 200;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] bri;
    } pixel_t;

    typedef struct {
        bit          is_cfg;
        int          reg_idx;
        logic [31:0] cfg_val;
        logic [15:0] amp;
        logic [15:0] freq;
        bit          typed;
        pixel_t      px;
    } dir_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;   // amp_sample [15:0], freq_sample [31:16]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [15:0]                     m_tdata;   // hue [7:0], brightness [15:8]
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [slhm_pkg::APB_ADDR_W-1:0] paddr;
    logic [slhm_pkg::APB_DATA_W-1:0] pwdata;
    logic [slhm_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    smoothed_level_to_hue_mapper_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the block's registers and history rings
    logic                           lvl_mode;
    logic [slhm_pkg::LEN_CFG_W-1:0] lvl_len;
    logic [15:0]                    amp_hist  [slhm_pkg::MAX_SMOOTH_DEF];
    logic [15:0]                    freq_hist [slhm_pkg::MAX_SMOOTH_DEF];

    pixel_t pixel_q[$];
    int     errs;
    bit     bursty;
    bit     hold_ask;

    localparam int DIR_N = 26;
    dir_row_t dir_tab [DIR_N] = '{
        '{0, 0, 32'd0, 16'h0000, 16'hFFFF, 1, '{8'd192, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'h0000, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_SMOOTH_LEN, 32'd0, 16'h0, 16'h0, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'h0000, 1, '{8'd0, 8'd255}},
        '{0, 0, 32'd0, 16'h0000, 16'h0000, 1, '{8'd192, 8'd0}},
        '{0, 0, 32'd0, 16'd6553, 16'h1234, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'd6554, 16'h4321, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_COLOR_MODE, 32'(slhm_pkg::MODE_FREQ), 16'h0, 16'h0, 0,
          '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'hFFFF, 1, '{8'd191, 8'd254}},
        '{0, 0, 32'd0, 16'h0000, 16'h0000, 1, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'd2570, 16'h5555, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'd2571, 16'hAAAA, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_SMOOTH_LEN, 32'd16, 16'h0, 16'h0, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'hFFFF, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'h0000, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_SMOOTH_LEN, 32'd31, 16'h0, 16'h0, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'h1234, 16'h8000, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'hFFFF, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_COLOR_MODE, 32'(slhm_pkg::MODE_AMP), 16'h0, 16'h0, 0,
          '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_SMOOTH_LEN, 32'd17, 16'h0, 16'h0, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'h8000, 16'h0000, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hFFFF, 16'hFFFF, 0, '{8'd0, 8'd0}},
        // freq ring must still hold what it had before amplitude mode
        '{1, slhm_pkg::REG_COLOR_MODE, 32'(slhm_pkg::MODE_FREQ), 16'h0, 16'h0, 0,
          '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'h0000, 16'hFFFF, 0, '{8'd0, 8'd0}},
        '{1, slhm_pkg::REG_SMOOTH_LEN, 32'd1, 16'h0, 16'h0, 0, '{8'd0, 8'd0}},
        '{0, 0, 32'd0, 16'hAAAA, 16'h5555, 0, '{8'd0, 8'd0}}
    };

    function automatic logic [15:0] smooth_level(bit is_freq, logic [15:0] sample);
        logic [31:0] sum;
        logic [15:0] avg;
        int          n;
        n = (lvl_len > slhm_pkg::MAX_SMOOTH_DEF) ? slhm_pkg::MAX_SMOOTH_DEF : int'(lvl_len);
        sum = 32'(sample);
        for (int i = 0; i < n; i++)
            sum += 32'(is_freq ? freq_hist[i] : amp_hist[i]);
        avg = 16'(sum / (n + 1));
        for (int i = slhm_pkg::MAX_SMOOTH_DEF - 1; i > 0; i--) begin
            if (is_freq)
                freq_hist[i] = freq_hist[i-1];
            else
                amp_hist[i] = amp_hist[i-1];
        end
        if (is_freq)
            freq_hist[0] = avg;
        else
            amp_hist[0] = avg;
        return avg;
    endfunction

    function automatic pixel_t map_levels(logic [15:0] amp, logic [15:0] freq);
        logic [31:0] a;
        logic [31:0] f;
        logic [31:0] hue;
        logic [31:0] bri;
        pixel_t      px;
        a = 32'(smooth_level(1'b0, amp));
        if (lvl_mode == slhm_pkg::MODE_AMP) begin
            hue = ((32'(slhm_pkg::HUE_SPAN) << 16) - 32'(slhm_pkg::HUE_SPAN) * a) >> 16;
            bri = (32'(slhm_pkg::AMP_ON_MUL) * a < 32'h10000) ? 32'd0
                                                             : 32'(slhm_pkg::BRI_FULL);
        end else begin
            f = 32'(smooth_level(1'b1, freq));
            hue = (32'(slhm_pkg::HUE_SPAN) * f) >> 16;
            bri = (32'(slhm_pkg::BRI_FULL) * a) >> 16;
            if (bri < 32'(slhm_pkg::BRI_MIN))
                bri = 32'd0;
        end
        if (hue > 32'(slhm_pkg::HUE_SPAN))
            hue = 32'(slhm_pkg::HUE_SPAN);
        if (bri > 32'(slhm_pkg::BRI_FULL))
            bri = 32'(slhm_pkg::BRI_FULL);
        px.hue = hue[7:0];
        px.bri = bri[7:0];
        return px;
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(2400, 6700));   // near brightness thresholds
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // called and returns at a falling edge; s_tvalid stays high on return
    task automatic offer_levels(input logic [15:0] amp, input logic [15:0] freq,
                                input int gap, input bit typed, input pixel_t typed_px);
        pixel_t px;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {freq, amp};
        do @(posedge aclk); while (s_tready !== 1'b1);
        px = map_levels(amp, freq);
        pixel_q.push_back(typed ? typed_px : px);
        @(negedge aclk);
    endtask

    task automatic drain_levels();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] val);
        logic [31:0] want;
        drain_levels();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= slhm_pkg::APB_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (idx == slhm_pkg::REG_COLOR_MODE)
            lvl_mode = val[0];
        else
            lvl_len = val[slhm_pkg::LEN_CFG_W-1:0];
        want = (idx == slhm_pkg::REG_COLOR_MODE) ? 32'(lvl_mode) : 32'(lvl_len);
        // read back, second transfer back to back
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want) begin
            $display("%0t: register %0d read expected %0h got %0h", $time, idx, want, prdata);
            errs++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : pixel_sink
        int     stall;
        pixel_t want;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = bursty ? $urandom_range(0, 5) : 0;
            if (hold_ask) begin
                stall = LONG_HOLD;
                hold_ask = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected item hue %0d brightness %0d", $time,
                         m_tdata[7:0], m_tdata[15:8]);
                errs++;
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[7:0] !== want.hue) begin
                    $display("%0t: hue expected %0d got %0d", $time, want.hue, m_tdata[7:0]);
                    errs++;
                end
                if (m_tdata[15:8] !== want.bri) begin
                    $display("%0t: brightness expected %0d got %0d", $time,
                             want.bri, m_tdata[15:8]);
                    errs++;
                end
            end
        end
    end

    initial begin : stimulus
        int                             sent;
        int                             n;
        int                             gap;
        logic                           phase_mode;
        logic [slhm_pkg::LEN_CFG_W-1:0] phase_len;
        errs     = 0;
        bursty   = 1'b1;
        hold_ask = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        lvl_mode = slhm_pkg::COLOR_MODE_RST;
        lvl_len  = slhm_pkg::SMOOTH_LEN_RST;
        for (int i = 0; i < slhm_pkg::MAX_SMOOTH_DEF; i++) begin
            amp_hist[i]  = '0;
            freq_hist[i] = '0;
        end
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_tab[r].is_cfg)
                write_reg(dir_tab[r].reg_idx, dir_tab[r].cfg_val);
            else
                offer_levels(dir_tab[r].amp, dir_tab[r].freq, $urandom_range(0, 5),
                             dir_tab[r].typed, dir_tab[r].px);
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            phase_mode = $urandom_range(0, 1) ? slhm_pkg::MODE_FREQ : slhm_pkg::MODE_AMP;
            case ($urandom_range(0, 4))
                0: phase_len = '0;
                1: phase_len = slhm_pkg::LEN_CFG_W'(1);
                2: phase_len = slhm_pkg::LEN_CFG_W'(slhm_pkg::MAX_SMOOTH_DEF);
                3: phase_len = '1;
                default: phase_len = slhm_pkg::LEN_CFG_W'($urandom_range(0, 31));
            endcase
            write_reg(slhm_pkg::REG_COLOR_MODE, 32'(phase_mode));
            write_reg(slhm_pkg::REG_SMOOTH_LEN, 32'(phase_len));
            bursty = ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 80);
            for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
                if (sent == 100)
                    hold_ask = 1'b1;
                if (sent == 300)
                    drain_levels();
                // keep offering back to back while the sink holds off
                gap = (bursty && !(sent >= 100 && sent < 112)) ? $urandom_range(0, 5) : 0;
                offer_levels(rand_level(), rand_level(), gap, 1'b0, '{8'd0, 8'd0});
                sent++;
            end
        end

        drain_levels();
        if (errs == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
